>>> hdl/ilirs_pkg.sv
// ----------------------------------------------------------------------------
// ilirs_pkg: shared types for the ordered list
// Holds the operation and status codes and the command that the controller
// broadcasts to every storage cell of the chain.
// ----------------------------------------------------------------------------
package ilirs_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [3:0] {
        OP_INSERT       = 4'd0,
        OP_APPEND       = 4'd1,
        OP_PREPEND      = 4'd2,
        OP_REMOVE_AT    = 4'd3,
        OP_REMOVE_LAST  = 4'd4,
        OP_REMOVE_FIRST = 4'd5,
        OP_SEARCH       = 4'd6,
        OP_OVERWRITE    = 4'd7,
        OP_READ         = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_EMPTY = 3'd2,
        ST_FULL  = 3'd3,
        ST_MISS  = 3'd4
    } t_status;

    // One command reaches all cells in the same cycle; each cell decides
    // locally by comparing its own index with the target position.
    typedef struct packed {
        logic              ins;        // open a gap at pos and store value
        logic              del;        // close the gap at pos
        logic              wr;         // overwrite the entry at pos
        logic              scan_load;  // copy entries into the scan line
        logic              scan_shift; // move the scan line one cell down
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

>>> hdl/ilirs_cell.sv
// ----------------------------------------------------------------------------
// ilirs_cell: one storage cell of the ordered list chain
// Holds one entry and one scan word. Shifts entries up or down with its
// neighbors and passes scan words toward cell zero.
// ----------------------------------------------------------------------------
module ilirs_cell #(
    parameter int IDX = 0,
    parameter int LW  = 9
) (
    input  logic                            i_clk,
    input  ilirs_pkg::t_cell_cmd            i_cmd,
    input  logic [LW-1:0]                   i_pos,
    input  logic [ilirs_pkg::DATA_W-1:0]    i_prev_entry,
    input  logic [ilirs_pkg::DATA_W-1:0]    i_next_entry,
    input  logic [ilirs_pkg::DATA_W-1:0]    i_next_scan,
    output logic [ilirs_pkg::DATA_W-1:0]    o_entry,
    output logic [ilirs_pkg::DATA_W-1:0]    o_scan
);

    localparam logic [LW-1:0] MY_IDX = LW'(IDX);

    logic [ilirs_pkg::DATA_W-1:0] r_entry;
    logic [ilirs_pkg::DATA_W-1:0] n_entry;
    logic [ilirs_pkg::DATA_W-1:0] r_scan;
    logic [ilirs_pkg::DATA_W-1:0] n_scan;
    logic                         at_pos;
    logic                         above_pos;

    assign at_pos    = (MY_IDX == i_pos);
    assign above_pos = (MY_IDX > i_pos);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (above_pos) begin
                n_entry = i_prev_entry;
            end else if (at_pos) begin
                n_entry = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (above_pos || at_pos) begin
                n_entry = i_next_entry;
            end
        end else if (i_cmd.wr && at_pos) begin
            n_entry = i_cmd.value;
        end
    end

    always_comb begin
        n_scan = r_scan;
        if (i_cmd.scan_load) begin
            n_scan = r_entry;
        end else if (i_cmd.scan_shift) begin
            n_scan = i_next_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_scan  <= n_scan;
    end

    assign o_entry = r_entry;
    assign o_scan  = r_scan;

endmodule

>>> hdl/indexed_list_insert_remove_search_top.sv
// Insert, append, prepend, removals, overwrite and failed checks give a
// registered result, one beat per cycle while no scan runs and the output
// is not stalled. Read and search load the scan line, which moves one cell
// per cycle toward cell zero, where the only comparator sits. A read stops
// at its position, a search at a match or the end; new beats stall meanwhile.
// Reset (synchronous, active low) empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_search_top: ordered list in a chain of cells
// Keeps up to CAPACITY unsigned 32-bit words in order with insert, remove, search,
// overwrite and read by position, and returns one result beat per item.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_search_top #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_opcode,
    input  logic [8:0]  i_position,
    input  logic [31:0] i_entry_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_read_data,
    output logic [7:0]  o_found_position,
    output logic [8:0]  o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = (CW > 9) ? CW : 9;
    localparam int DW = ilirs_pkg::DATA_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    ilirs_pkg::t_status   r_status;
    logic [DW-1:0]        r_rdata;
    logic [7:0]           r_found;
    logic [8:0]           r_cnt_out;
    logic                 r_is_search;
    logic [DW-1:0]        r_key;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_last;

    ilirs_pkg::t_cell_cmd cmd;
    logic [LW-1:0]        cmd_pos;
    ilirs_pkg::t_status   acc_status;
    logic [CW-1:0]        acc_count;
    logic                 acc_scan;
    logic                 acc_search;
    logic                 accept;
    logic                 slot_free;
    logic                 full;
    logic                 empty;
    logic [LW-1:0]        pos_x;
    logic [LW-1:0]        cnt_x;
    logic                 scan_hit;
    logic                 scan_end;
    logic                 scan_done;

    logic [DW-1:0]        w_entry [CAPACITY];
    logic [DW-1:0]        w_scan  [CAPACITY];

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !slot_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);
    assign pos_x = LW'(i_position);
    assign cnt_x = LW'(r_count);

    // Scan state: the word at cell zero is compared each cycle.
    assign scan_end  = (r_idx == r_last);
    assign scan_hit  = r_is_search ? (w_scan[0] == r_key) : scan_end;
    assign scan_done = (r_state == S_SCAN) && slot_free && (scan_hit || scan_end);

    always_comb begin
        cmd            = '0;
        cmd.value      = i_entry_value;
        cmd_pos        = pos_x;
        acc_status     = ilirs_pkg::ST_OK;
        acc_count      = r_count;
        acc_scan       = 1'b0;
        acc_search     = 1'b0;
        case (ilirs_pkg::t_opcode'(i_opcode))
            ilirs_pkg::OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    acc_status = ilirs_pkg::ST_RANGE;
                end else if (full) begin
                    acc_status = ilirs_pkg::ST_FULL;
                end else begin
                    cmd.ins   = 1'b1;
                    acc_count = r_count + CW'(1);
                end
            end
            ilirs_pkg::OP_APPEND: begin
                cmd_pos = cnt_x;
                if (full) begin
                    acc_status = ilirs_pkg::ST_FULL;
                end else begin
                    cmd.ins   = 1'b1;
                    acc_count = r_count + CW'(1);
                end
            end
            ilirs_pkg::OP_PREPEND: begin
                cmd_pos = '0;
                if (full) begin
                    acc_status = ilirs_pkg::ST_FULL;
                end else begin
                    cmd.ins   = 1'b1;
                    acc_count = r_count + CW'(1);
                end
            end
            ilirs_pkg::OP_REMOVE_AT: begin
                if (empty) begin
                    acc_status = ilirs_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    acc_status = ilirs_pkg::ST_RANGE;
                end else begin
                    cmd.del   = 1'b1;
                    acc_count = r_count - CW'(1);
                end
            end
            ilirs_pkg::OP_REMOVE_LAST: begin
                cmd_pos = cnt_x - LW'(1);
                if (empty) begin
                    acc_status = ilirs_pkg::ST_EMPTY;
                end else begin
                    cmd.del   = 1'b1;
                    acc_count = r_count - CW'(1);
                end
            end
            ilirs_pkg::OP_REMOVE_FIRST: begin
                cmd_pos = '0;
                if (empty) begin
                    acc_status = ilirs_pkg::ST_EMPTY;
                end else begin
                    cmd.del   = 1'b1;
                    acc_count = r_count - CW'(1);
                end
            end
            ilirs_pkg::OP_SEARCH: begin
                if (empty) begin
                    acc_status = ilirs_pkg::ST_MISS;
                end else begin
                    acc_scan   = 1'b1;
                    acc_search = 1'b1;
                end
            end
            ilirs_pkg::OP_OVERWRITE: begin
                if (pos_x >= cnt_x) begin
                    acc_status = ilirs_pkg::ST_RANGE;
                end else begin
                    cmd.wr = 1'b1;
                end
            end
            ilirs_pkg::OP_READ: begin
                if (pos_x >= cnt_x) begin
                    acc_status = ilirs_pkg::ST_RANGE;
                end else begin
                    acc_scan = 1'b1;
                end
            end
            default: begin
                acc_status = ilirs_pkg::ST_OK;
            end
        endcase
        if (!accept) begin
            cmd.ins = 1'b0;
            cmd.del = 1'b0;
            cmd.wr  = 1'b0;
        end
        cmd.scan_load  = accept && acc_scan;
        cmd.scan_shift = (r_state == S_SCAN) && slot_free && !scan_hit && !scan_end;
    end

    // A new result is loaded when a direct beat is taken or a scan ends;
    // otherwise the held result clears once the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if ((accept && !acc_scan) || scan_done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= acc_count;
                        if (acc_scan) begin
                            r_state     <= S_SCAN;
                            r_is_search <= acc_search;
                            r_key       <= i_entry_value;
                            r_idx       <= '0;
                            r_last      <= acc_search ? IW'(r_count - CW'(1))
                                                      : IW'(pos_x);
                        end else begin
                            r_status    <= acc_status;
                            r_rdata     <= '0;
                            r_found     <= '0;
                            r_cnt_out   <= 9'(acc_count);
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state     <= S_IDLE;
                        r_cnt_out   <= 9'(r_count);
                        if (scan_hit) begin
                            r_status <= ilirs_pkg::ST_OK;
                            r_rdata  <= r_is_search ? '0 : w_scan[0];
                            r_found  <= r_is_search ? 8'(r_idx) : 8'd0;
                        end else begin
                            r_status <= ilirs_pkg::ST_MISS;
                            r_rdata  <= '0;
                            r_found  <= '0;
                        end
                    end else if (cmd.scan_shift) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DW-1:0] prev_entry;
        logic [DW-1:0] next_entry;
        logic [DW-1:0] next_scan;

        if (g == 0) begin : g_first
            assign prev_entry = '0;
        end else begin : g_mid
            assign prev_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_entry = '0;
            assign next_scan  = '0;
        end else begin : g_inner
            assign next_entry = w_entry[g+1];
            assign next_scan  = w_scan[g+1];
        end

        ilirs_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_pos        (cmd_pos),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .i_next_scan  (next_scan),
            .o_entry      (w_entry[g]),
            .o_scan       (w_scan[g])
        );
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_read_data      = r_rdata;
    assign o_found_position = r_found;
    assign o_entry_count    = r_cnt_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("entry count changed without an accepted beat");

    a_search_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == ilirs_pkg::OP_SEARCH && r_count != '0)
            |=> (r_state == S_SCAN))
        else $error("search on a nonempty list did not start a scan");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !(cmd.ins || cmd.del || cmd.wr))
        else $error("list modified while a scan is running");
`endif

endmodule
